### rtl/mcmp_pkg.sv
// shared types and constants for the midi channel message parser
`default_nettype none

package mcmp_pkg;

    // status and system byte codes
    localparam logic [7:0] STATUS_FIRST = 8'h80;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_END    = 8'hF7;

    // message kinds, coded from the status high nibble minus eight
    localparam logic [2:0] KIND_NOTE_OFF      = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON       = 3'd1;
    localparam logic [2:0] KIND_POLY_PRESSURE = 3'd2;
    localparam logic [2:0] KIND_CONTROL       = 3'd3;
    localparam logic [2:0] KIND_PROGRAM       = 3'd4;
    localparam logic [2:0] KIND_CHAN_PRESSURE = 3'd5;
    localparam logic [2:0] KIND_PITCH_BEND    = 3'd6;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] channel;
        logic [7:0] first;
        logic [7:0] second;
    } msg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // kinds that carry a single data byte
    function automatic logic is_one_byte_kind(input logic [2:0] kind);
        is_one_byte_kind = (kind == KIND_PROGRAM) || (kind == KIND_CHAN_PRESSURE);
    endfunction

endpackage

`default_nettype wire

### rtl/mcmp_if.sv
// handshake channels for raw bytes and parsed messages
`default_nettype none

interface mcmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mcmp_msg_if;
    logic       valid;
    logic       ready;
    logic [2:0] msg_kind;
    logic [3:0] msg_channel;
    logic [7:0] data_first;
    logic [7:0] data_second;

    modport source (output valid, output msg_kind, output msg_channel,
                    output data_first, output data_second, input ready);
    modport sink   (input valid, input msg_kind, input msg_channel,
                    input data_first, input data_second, output ready);
endinterface

`default_nettype wire

### rtl/midi_channel_message_parser_unit.sv
// top level of the midi channel voice message parser
//
// byte_in carries one received midi byte per beat; msg_out carries one
// parsed channel voice message per beat (kind, channel, two data bytes,
// the second zero for program change and channel pressure).
// sysex is skipped up to its end byte, stray bytes while waiting for a
// status byte are dropped, running status is not supported.
// throughput: one byte per cycle, sustained, with the receiver ready.
// a message is written to the queue at the beat of its last data byte and is
// then moved into the output register, from which msg_out presents it.
// the front parser, a two-entry queue and the output register stall
// independently; byte_in.ready drops only while the queue is full, so a
// stalled receiver holds the current message steady and back-pressure
// reaches the byte side after two more messages are waiting.
// reset clears the parser to wait for a status byte and empties the
// queue and the output register; no clearing pass is needed.
`default_nettype none

module midi_channel_message_parser_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mcmp_byte_if.sink  byte_in,
    mcmp_msg_if.source msg_out
);
    import mcmp_pkg::*;

    // front to queue
    logic        push;
    msg_t        push_msg;
    // queue to back
    logic        pop;
    msg_t        head_msg;
    queue_stat_t q_stat;

    // status/data classification and parser state
    mcmp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_in),
        .q_stat   (q_stat),
        .push     (push),
        .push_msg (push_msg)
    );

    // decouples parser from output stalls
    mcmp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_msg (push_msg),
        .pop      (pop),
        .head_msg (head_msg),
        .q_stat   (q_stat)
    );

    // registered output beat
    mcmp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head_msg (head_msg),
        .pop      (pop),
        .msg_out  (msg_out)
    );

endmodule

`default_nettype wire

### rtl/mcmp_front.sv
// byte classifier and parser state, pushes completed messages
`default_nettype none

module mcmp_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    mcmp_byte_if.sink                 byte_in,
    input  wire mcmp_pkg::queue_stat_t q_stat,
    output logic                      push,
    output mcmp_pkg::msg_t            push_msg
);
    import mcmp_pkg::*;

    logic       awaiting_reg, awaiting_next;
    logic       sysex_reg, sysex_next;
    logic       have_first_reg, have_first_next;
    logic [2:0] kind_reg, kind_next;
    logic [3:0] chan_reg, chan_next;
    logic [7:0] held_reg, held_next;
    logic       accept;
    logic       one_byte;
    logic [7:0] b;

    assign byte_in.ready = !q_stat.full;
    assign accept        = byte_in.valid && byte_in.ready;
    assign b             = byte_in.rx_byte;
    assign one_byte      = is_one_byte_kind(kind_reg);

    always_comb
    begin
        awaiting_next   = awaiting_reg;
        sysex_next      = sysex_reg;
        have_first_next = have_first_reg;
        kind_next       = kind_reg;
        chan_next       = chan_reg;
        held_next       = held_reg;
        push            = 1'b0;
        push_msg.kind    = kind_reg;
        push_msg.channel = chan_reg;
        push_msg.first   = one_byte ? b : held_reg;
        push_msg.second  = one_byte ? 8'h00 : b;
        if (accept)
        begin
            priority if (awaiting_reg)
            begin
                if (b >= STATUS_FIRST && b < SYSEX_START)
                begin
                    kind_next       = b[6:4];
                    chan_next       = b[3:0];
                    have_first_next = 1'b0;
                    awaiting_next   = 1'b0;
                end
                else if (b == SYSEX_START)
                begin
                    awaiting_next = 1'b0;
                    sysex_next    = 1'b1;
                end
            end
            else if (sysex_reg)
            begin
                if (b == SYSEX_END)
                begin
                    sysex_next    = 1'b0;
                    awaiting_next = 1'b1;
                end
            end
            else if (!one_byte && !have_first_reg)
            begin
                held_next       = b;
                have_first_next = 1'b1;
            end
            else
            begin
                push          = 1'b1;
                awaiting_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg   <= 1'b1;
            sysex_reg      <= 1'b0;
            have_first_reg <= 1'b0;
        end
        else
        begin
            awaiting_reg   <= awaiting_next;
            sysex_reg      <= sysex_next;
            have_first_reg <= have_first_next;
        end
    end

    // message payload, no reset
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        chan_reg <= chan_next;
        held_reg <= held_next;
    end

endmodule

`default_nettype wire

### rtl/mcmp_queue.sv
// two-entry message queue between parser and output stage
`default_nettype none

module mcmp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mcmp_pkg::msg_t    push_msg,
    input  wire logic              pop,
    output mcmp_pkg::msg_t         head_msg,
    output mcmp_pkg::queue_stat_t  q_stat
);
    import mcmp_pkg::*;

    msg_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_msg     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_msg;
        end
    end

endmodule

`default_nettype wire

### rtl/mcmp_back.sv
// output register that drives the message channel
`default_nettype none

module mcmp_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mcmp_pkg::queue_stat_t q_stat,
    input  wire mcmp_pkg::msg_t        head_msg,
    output logic                       pop,
    mcmp_msg_if.source                 msg_out
);
    import mcmp_pkg::*;

    logic valid_reg, valid_next;
    msg_t out_reg;

    // refill whenever the register is empty or being drained
    assign pop        = !q_stat.empty && (!valid_reg || msg_out.ready);
    assign valid_next = pop || (valid_reg && !msg_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= head_msg;
        end
    end

    assign msg_out.valid       = valid_reg;
    assign msg_out.msg_kind    = out_reg.kind;
    assign msg_out.msg_channel = out_reg.channel;
    assign msg_out.data_first  = out_reg.first;
    assign msg_out.data_second = out_reg.second;

endmodule

`default_nettype wire
